// File: rtl/core/dsss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsss_pkg: shared types for the dual stack shared store core
// Request and result layouts, operation and status codes, and the command
// that the front part hands through the queue to the back part.
// ----------------------------------------------------------------------------
package dsss_pkg;

	localparam int COUNT_W  = 4;
	localparam int WORD_W   = 32;
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = 1;
	localparam int QCOUNT_W = 2;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2
	} dsss_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} dsss_status_t;

	typedef struct packed {
		logic [1:0]               operation;
		logic                     stack_select;
		logic signed [WORD_W-1:0] push_value;
	} dsss_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] top_value;
		dsss_status_t             status;
		logic [COUNT_W-1:0]       lower_count;
		logic [COUNT_W-1:0]       upper_count;
	} dsss_rsp_t;

	// classified command: what the back part does with the store
	typedef struct packed {
		logic               wr;
		logic               rd;
		dsss_status_t       status;
		logic [COUNT_W-1:0] lower_count;
		logic [COUNT_W-1:0] upper_count;
	} dsss_ctl_t;

endpackage

// File: rtl/core/dsss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsss_front: request intake and classification
// Holds both fill counts, decides status and store address for each item
// and queues the resulting command for the back part.
// ----------------------------------------------------------------------------
module dsss_front
	import dsss_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  dsss_req_t                     request,
	input  logic                          q_full,
	output logic                          q_push,
	output dsss_ctl_t                     q_ctl,
	output logic [$clog2(CAPACITY)-1:0]   q_addr,
	output logic [WORD_W-1:0]             q_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]         lower_q, upper_q;
	logic [CW-1:0]         lower_nxt, upper_nxt;
	logic [CW:0]           fill_sum;
	logic                  store_full;
	logic                  accept;
	logic [CW-1:0]         addr_wide;
	logic [CW+COUNT_W-1:0] lower_ext, upper_ext;

	assign busy     = q_full;
	assign accept   = start && !busy;
	assign q_push   = accept;
	assign q_data   = request.push_value;
	assign fill_sum = {1'b0, lower_q} + {1'b0, upper_q};
	assign store_full = fill_sum >= (CW+1)'(CAPACITY);

	always_comb begin
		lower_nxt = lower_q;
		upper_nxt = upper_q;
		addr_wide = '0;
		q_ctl     = '0;
		q_ctl.status = ST_OK;
		case (request.operation)
			OP_PUSH: begin
				if (store_full) begin
					q_ctl.status = ST_OVERFLOW;
				end else if (!request.stack_select) begin
					q_ctl.wr  = 1'b1;
					addr_wide = lower_q;
					lower_nxt = lower_q + CW'(1);
				end else begin
					q_ctl.wr  = 1'b1;
					addr_wide = CW'(CAPACITY - 1) - upper_q;
					upper_nxt = upper_q + CW'(1);
				end
			end
			OP_POP, OP_PEEK: begin
				if (!request.stack_select) begin
					if (lower_q == '0) begin
						q_ctl.status = ST_UNDERFLOW;
					end else begin
						q_ctl.rd  = 1'b1;
						addr_wide = lower_q - CW'(1);
						if (request.operation == OP_POP) begin
							lower_nxt = lower_q - CW'(1);
						end
					end
				end else begin
					if (upper_q == '0) begin
						q_ctl.status = ST_UNDERFLOW;
					end else begin
						q_ctl.rd  = 1'b1;
						addr_wide = CW'(CAPACITY) - upper_q;
						if (request.operation == OP_POP) begin
							upper_nxt = upper_q - CW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
		lower_ext = {{COUNT_W{1'b0}}, lower_nxt};
		upper_ext = {{COUNT_W{1'b0}}, upper_nxt};
		q_ctl.lower_count = lower_ext[COUNT_W-1:0];
		q_ctl.upper_count = upper_ext[COUNT_W-1:0];
	end

	assign q_addr = addr_wide[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= '0;
		end else if (accept) begin
			lower_q <= lower_nxt;
			upper_q <= upper_nxt;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, lower_q} + {1'b0, upper_q}) <= (CW+1)'(CAPACITY))
		else $error("stack fills exceed store capacity");

	a_overflow_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_ctl.status == ST_OVERFLOW |=>
		lower_q == $past(lower_q) && upper_q == $past(upper_q))
		else $error("overflowing push changed a fill count");

	a_lower_pop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && q_ctl.rd && request.operation == OP_POP && !request.stack_select |=>
		lower_q == $past(lower_q) - CW'(1))
		else $error("lower pop did not shrink the lower stack");

endmodule

// File: rtl/core/dsss_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsss_queue: short command queue between front and back
// Two-entry fifo of classified commands; the back drains one a cycle.
// ----------------------------------------------------------------------------
module dsss_queue
	import dsss_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dsss_ctl_t                     push_ctl,
	input  logic [$clog2(CAPACITY)-1:0]   push_addr,
	input  logic [WORD_W-1:0]             push_data,
	output logic                          full,
	output logic                          pop,
	output dsss_ctl_t                     pop_ctl,
	output logic [$clog2(CAPACITY)-1:0]   pop_addr,
	output logic [WORD_W-1:0]             pop_data
);

	localparam int AW = $clog2(CAPACITY);

	dsss_ctl_t           ctl_q  [QDEPTH];
	logic [AW-1:0]       addr_q [QDEPTH];
	logic [WORD_W-1:0]   data_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;

	assign full = count_q == QCOUNT_W'(QDEPTH);
	assign pop  = count_q != '0;

	assign pop_ctl  = ctl_q[rd_ptr_q];
	assign pop_addr = addr_q[rd_ptr_q];
	assign pop_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= push_ctl;
			addr_q[wr_ptr_q] <= push_addr;
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCOUNT_W'(push) - QCOUNT_W'(pop);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("item queued while queue full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - QCOUNT_W'(1))
		else $error("queue did not drain");

endmodule

// File: rtl/core/dsss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsss_back: store access and result register
// Owns the shared store; writes pushes, reads pops and peeks, and presents
// one result per command on the cycle after the store access.
// ----------------------------------------------------------------------------
module dsss_back
	import dsss_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	input  dsss_ctl_t                     ctl,
	input  logic [$clog2(CAPACITY)-1:0]   addr,
	input  logic [WORD_W-1:0]             data,
	output logic                          done,
	output dsss_rsp_t                     result
);

	logic [WORD_W-1:0]  store_q [CAPACITY];
	logic [WORD_W-1:0]  rdata_s1;
	logic               rd_s1;
	dsss_status_t       status_s1;
	logic [COUNT_W-1:0] lower_s1, upper_s1;
	logic               done_s1;

	always_ff @(posedge clk) begin
		if (valid && ctl.wr) begin
			store_q[addr] <= data;
		end
		if (valid && ctl.rd) begin
			rdata_s1 <= store_q[addr];
		end
		if (valid) begin
			rd_s1     <= ctl.rd;
			status_s1 <= ctl.status;
			lower_s1  <= ctl.lower_count;
			upper_s1  <= ctl.upper_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= valid;
		end
	end

	assign done               = done_s1;
	assign result.top_value   = rd_s1 ? rdata_s1 : '0;
	assign result.status      = status_s1;
	assign result.lower_count = lower_s1;
	assign result.upper_count = upper_s1;

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !(ctl.wr && ctl.rd))
		else $error("command both writes and reads the store");

	a_ok_on_access: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (ctl.wr || ctl.rd) |-> ctl.status == ST_OK)
		else $error("store access on a failed command");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> done)
		else $error("command produced no result");

endmodule

// File: rtl/core/dual_stack_shared_store_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_store_core: two stacks sharing one word store
// Lower stack grows up from entry 0, upper stack grows down from the last
// entry; push, pop and peek requests report status and both fill counts.
// ----------------------------------------------------------------------------
// usage:
//   request channel: drive request and raise start; the item is taken at a
//   rising edge with start high and busy low. busy is high only while the
//   two-entry command queue is full, which the back part drains every cycle.
//   result channel: done pulses for exactly one cycle with result valid in
//   that cycle; the receiver must take it then, there is no back-pressure.
//   path: an accepted item is written into the command queue, then the back
//   part accesses the store and registers the result together with done.
//   throughput: one item per cycle while busy is low; fills are updated in
//   the front at acceptance, the back writes or reads the store in the next cycle.
//   reset: arst_n clears both fill counts, the queue and done; the store
//   content is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module dual_stack_shared_store_core
	import dsss_pkg::*;
#(
	parameter int CAPACITY = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  dsss_req_t request,
	output logic      done,
	output dsss_rsp_t result
);

	localparam int AW = $clog2(CAPACITY);

	logic              q_push, q_full, q_pop;
	dsss_ctl_t         in_ctl, out_ctl;
	logic [AW-1:0]     in_addr, out_addr;
	logic [WORD_W-1:0] in_data, out_data;

	dsss_front #(.CAPACITY(CAPACITY)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_ctl   (in_ctl),
		.q_addr  (in_addr),
		.q_data  (in_data)
	);

	dsss_queue #(.CAPACITY(CAPACITY)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_ctl  (in_ctl),
		.push_addr (in_addr),
		.push_data (in_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_ctl   (out_ctl),
		.pop_addr  (out_addr),
		.pop_data  (out_data)
	);

	dsss_back #(.CAPACITY(CAPACITY)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (q_pop),
		.ctl    (out_ctl),
		.addr   (out_addr),
		.data   (out_data),
		.done   (done),
		.result (result)
	);

	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching accepted item");

	a_top_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.top_value == '0)
		else $error("failed item returned a nonzero top value");

	a_busy_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> q_full)
		else $error("busy raised with room in the queue");

endmodule
